[rtl/dps_pkg.sv]
// ----------------------------------------------------------------------------
// dps_pkg
// shared constants, register indexes, fault codes and control structs for the
// dual pedal sensor normalizer
// ----------------------------------------------------------------------------
package dps_pkg;

  localparam int SAMPLE_BITS_DEF         = 16;
  localparam int LEVEL_FRACTION_BITS_DEF = 16;
  localparam int CFG_INDEX_BITS          = 3;

  localparam logic [CFG_INDEX_BITS-1:0] REG_FLOOR     = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CEIL      = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_START_MIN = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_START_MAX = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_A_LOW     = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_A_HIGH    = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_B_LOW     = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] REG_B_HIGH    = 3'd7;

  localparam int DEF_FLOOR     = 1000;
  localparam int DEF_CEIL      = 4600;
  localparam int DEF_START_MIN = 1200;
  localparam int DEF_START_MAX = 4000;
  localparam int DEF_A_LOW     = 1000;
  localparam int DEF_A_HIGH    = 4600;
  localparam int DEF_B_LOW     = 500;
  localparam int DEF_B_HIGH    = 2300;

  localparam logic [1:0] FAULT_NONE     = 2'd0;
  localparam logic [1:0] FAULT_MISMATCH = 2'd1;
  localparam logic [1:0] FAULT_WINDOW   = 2'd2;

  typedef struct packed {
    logic load_in;
    logic decide;
    logic setup;
    logic div_step;
    logic load_out;
  } dps_cmd_t;

  typedef struct packed {
    logic need_div;
  } dps_status_t;

endpackage

[rtl/dps_if.sv]
// ----------------------------------------------------------------------------
// dps channel interfaces
// sample request channel, result channel and configuration write channel
// ----------------------------------------------------------------------------
interface dps_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sensor_a_reading;
  logic [SAMPLE_BITS-1:0] sensor_b_reading;

  modport source (output valid, output sensor_a_reading, output sensor_b_reading,
                  input ready);
  modport sink (input valid, input sensor_a_reading, input sensor_b_reading,
                output ready);
endinterface

interface dps_out_if #(
  parameter int SAMPLE_BITS         = 16,
  parameter int LEVEL_FRACTION_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic [LEVEL_FRACTION_BITS:0] pedal_level_q16;
  logic [1:0]                   fault_kind;
  logic                         mismatch_sticky;
  logic                         window_sticky;
  logic [SAMPLE_BITS-1:0]       learned_min_out;
  logic [SAMPLE_BITS-1:0]       learned_max_out;

  modport source (output valid, output pedal_level_q16, output fault_kind,
                  output mismatch_sticky, output window_sticky,
                  output learned_min_out, output learned_max_out, input ready);
  modport sink (input valid, input pedal_level_q16, input fault_kind,
                input mismatch_sticky, input window_sticky,
                input learned_min_out, input learned_max_out, output ready);
endinterface

interface dps_cfg_if #(
  parameter int SAMPLE_BITS = 16,
  parameter int INDEX_BITS  = 3
);
  logic                   valid;
  logic                   ready;
  logic [INDEX_BITS-1:0]  index;
  logic [SAMPLE_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/dps_datapath.sv]
// ----------------------------------------------------------------------------
// dps_datapath
// plausibility checks, learned bounds, restoring divider and result register
// ----------------------------------------------------------------------------
module dps_datapath
  import dps_pkg::*;
#(
  parameter int SAMPLE_BITS         = SAMPLE_BITS_DEF,
  parameter int LEVEL_FRACTION_BITS = LEVEL_FRACTION_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  dps_cmd_t                     cmd,
  output dps_status_t                  status,
  input  logic [SAMPLE_BITS-1:0]       sensor_a_reading,
  input  logic [SAMPLE_BITS-1:0]       sensor_b_reading,
  input  logic                         cfg_write,
  input  logic [CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [SAMPLE_BITS-1:0]       cfg_data,
  output logic [LEVEL_FRACTION_BITS:0] pedal_level_q16,
  output logic [1:0]                   fault_kind,
  output logic                         mismatch_sticky,
  output logic                         window_sticky,
  output logic [SAMPLE_BITS-1:0]       learned_min_out,
  output logic [SAMPLE_BITS-1:0]       learned_max_out
);

  localparam int SW   = SAMPLE_BITS;
  localparam int LW   = LEVEL_FRACTION_BITS + 1;
  localparam int MULW = SAMPLE_BITS + 6;
  localparam logic [LW-1:0] LEVEL_ONE = {1'b1, {(LW-1){1'b0}}};

  logic [SW-1:0] floor_lim, ceil_lim, a_low, a_high, b_low, b_high;
  logic [SW-1:0] learned_min, learned_max;
  logic          mismatch_flag, window_flag;

  logic [SW-1:0] b_q;
  logic [SW:0]   diff_q;
  logic [SW:0]   v_q;
  logic          win_bad_q;
  logic [1:0]    kind_q;
  logic [SW-1:0] rem_q, den_q;
  logic [LW-1:0] level_q;

  logic [SW:0]   a_ext, twice_b, diff;
  logic [SW+1:0] v_sum;
  logic          win_bad;
  logic [MULW-1:0] prod;
  logic          mism;
  logic          fault, span_bad, v_low, v_full;
  logic [SW:0]   rem2;
  logic          ge;

  // sample screening at accept
  always_comb begin
    a_ext   = {1'b0, sensor_a_reading};
    twice_b = {sensor_b_reading, 1'b0};
    diff    = (a_ext >= twice_b) ? (a_ext - twice_b) : (twice_b - a_ext);
    v_sum   = {1'b0, a_ext} + {1'b0, twice_b};
    win_bad = (sensor_a_reading < a_low) || (sensor_a_reading > a_high) ||
              (sensor_b_reading < b_low) || (sensor_b_reading > b_high);
  end

  // 25 * diff against b
  always_comb begin
    prod = (MULW'(diff_q) << 4) + (MULW'(diff_q) << 3) + MULW'(diff_q);
    mism = prod > MULW'(b_q);
  end

  always_comb begin
    fault    = kind_q != FAULT_NONE;
    span_bad = learned_max <= learned_min;
    v_low    = v_q <= {1'b0, learned_min};
    v_full   = v_q >= {1'b0, learned_max};
    status.need_div = !fault && !span_bad && !v_low && !v_full;
    rem2 = {rem_q, 1'b0};
    ge   = rem2 >= {1'b0, den_q};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      floor_lim     <= SW'(DEF_FLOOR);
      ceil_lim      <= SW'(DEF_CEIL);
      a_low         <= SW'(DEF_A_LOW);
      a_high        <= SW'(DEF_A_HIGH);
      b_low         <= SW'(DEF_B_LOW);
      b_high        <= SW'(DEF_B_HIGH);
      learned_min   <= SW'(DEF_START_MIN);
      learned_max   <= SW'(DEF_START_MAX);
      mismatch_flag <= 1'b0;
      window_flag   <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_FLOOR:     floor_lim   <= cfg_data;
          REG_CEIL:      ceil_lim    <= cfg_data;
          REG_START_MIN: learned_min <= cfg_data;
          REG_START_MAX: learned_max <= cfg_data;
          REG_A_LOW:     a_low       <= cfg_data;
          REG_A_HIGH:    a_high      <= cfg_data;
          REG_B_LOW:     b_low       <= cfg_data;
          REG_B_HIGH:    b_high      <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.decide) begin
        if (mism) begin
          mismatch_flag <= 1'b1;
        end else if (win_bad_q) begin
          window_flag <= 1'b1;
        end else begin
          if (v_q < {1'b0, learned_min}) begin
            learned_min <= (v_q < {1'b0, floor_lim}) ? floor_lim : v_q[SW-1:0];
          end
          if (v_q > {1'b0, learned_max}) begin
            learned_max <= (v_q > {1'b0, ceil_lim}) ? ceil_lim : v_q[SW-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      b_q       <= sensor_b_reading;
      diff_q    <= diff;
      v_q       <= v_sum[SW+1:1];
      win_bad_q <= win_bad;
    end
    if (cmd.decide) begin
      kind_q <= mism ? FAULT_MISMATCH : (win_bad_q ? FAULT_WINDOW : FAULT_NONE);
    end
    if (cmd.setup) begin
      level_q <= (!fault && !span_bad && !v_low && v_full) ? LEVEL_ONE : '0;
      rem_q   <= v_q[SW-1:0] - learned_min;
      den_q   <= learned_max - learned_min;
    end
    if (cmd.div_step) begin
      rem_q   <= ge ? SW'(rem2 - {1'b0, den_q}) : rem2[SW-1:0];
      level_q <= {level_q[LW-2:0], ge};
    end
    if (cmd.load_out) begin
      pedal_level_q16 <= level_q;
      fault_kind      <= kind_q;
      mismatch_sticky <= mismatch_flag;
      window_sticky   <= window_flag;
      learned_min_out <= learned_min;
      learned_max_out <= learned_max;
    end
  end

endmodule

[rtl/dps_ctrl.sv]
// ----------------------------------------------------------------------------
// dps_ctrl
// sequencer for one sample: screen, decide, divider setup, divide, hand off
// ----------------------------------------------------------------------------
module dps_ctrl
  import dps_pkg::*;
#(
  parameter int LEVEL_FRACTION_BITS = LEVEL_FRACTION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  output dps_cmd_t    cmd,
  input  dps_status_t status
);

  localparam int CW = $clog2(LEVEL_FRACTION_BITS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SETUP,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

  state_t        state;
  logic [CW-1:0] cnt;

  always_comb begin
    in_ready     = state == ST_IDLE;
    cmd.load_in  = (state == ST_IDLE) && in_valid;
    cmd.decide   = state == ST_DECIDE;
    cmd.setup    = state == ST_SETUP;
    cmd.div_step = state == ST_DIVIDE;
    cmd.load_out = (state == ST_FINISH) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          state <= ST_SETUP;
        end
        ST_SETUP: begin
          cnt   <= '0;
          state <= status.need_div ? ST_DIVIDE : ST_FINISH;
        end
        ST_DIVIDE: begin
          if (cnt == CW'(LEVEL_FRACTION_BITS - 1)) begin
            state <= ST_FINISH;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_FINISH: begin
          if (cmd.load_out) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/dual_pedal_sensor_normalizer_top.sv]
// ----------------------------------------------------------------------------
// dual_pedal_sensor_normalizer_top
// a taken request is registered, then passes decide, divider setup, the
// one-bit-per-cycle restoring divider (skipped on a fault or when no division
// is needed) and finish, which fills the output register once it is free;
// loading it frees the input side; no new request is taken before that
// reset: synchronous, restores register defaults, learned bounds and clears flags
// ----------------------------------------------------------------------------
module dual_pedal_sensor_normalizer_top
  import dps_pkg::*;
#(
  parameter int SAMPLE_BITS         = SAMPLE_BITS_DEF,
  parameter int LEVEL_FRACTION_BITS = LEVEL_FRACTION_BITS_DEF
) (
  input logic      clk,
  input logic      rst,
  dps_in_if.sink   samples,
  dps_out_if.source results,
  dps_cfg_if.sink  cfg
);

  dps_cmd_t    cmd;
  dps_status_t status;

  assign cfg.ready = 1'b1;

  dps_ctrl #(
    .LEVEL_FRACTION_BITS(LEVEL_FRACTION_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .cmd       (cmd),
    .status    (status)
  );

  dps_datapath #(
    .SAMPLE_BITS        (SAMPLE_BITS),
    .LEVEL_FRACTION_BITS(LEVEL_FRACTION_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .sensor_a_reading (samples.sensor_a_reading),
    .sensor_b_reading (samples.sensor_b_reading),
    .cfg_write        (cfg.valid & cfg.ready),
    .cfg_index        (cfg.index),
    .cfg_data         (cfg.data),
    .pedal_level_q16  (results.pedal_level_q16),
    .fault_kind       (results.fault_kind),
    .mismatch_sticky  (results.mismatch_sticky),
    .window_sticky    (results.window_sticky),
    .learned_min_out  (results.learned_min_out),
    .learned_max_out  (results.learned_max_out)
  );

endmodule

[rtl/dps_checker.sv]
// ----------------------------------------------------------------------------
// dps_checker
// port-level checks on the result channel, bound to the top level
// ----------------------------------------------------------------------------
module dps_checker
  import dps_pkg::*;
#(
  parameter int LEVEL_FRACTION_BITS = LEVEL_FRACTION_BITS_DEF
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [LEVEL_FRACTION_BITS:0] level,
  input logic [1:0]                   kind,
  input logic                         msticky,
  input logic                         wsticky
);

  a_fault_zero_level: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind != FAULT_NONE) |-> level == '0)
    else $error("faulted result carries nonzero level");

  a_mismatch_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == FAULT_MISMATCH) |-> msticky && (level == '0))
    else $error("mismatch result without sticky flag");

  a_window_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == FAULT_WINDOW) |-> wsticky)
    else $error("window result without sticky flag");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && level[LEVEL_FRACTION_BITS] |-> level[LEVEL_FRACTION_BITS-1:0] == '0)
    else $error("level above full travel");

  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(level) && $stable(kind))
    else $error("result dropped while stalled");

endmodule

bind dual_pedal_sensor_normalizer_top dps_checker #(
  .LEVEL_FRACTION_BITS(LEVEL_FRACTION_BITS)
) u_dps_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .level     (results.pedal_level_q16),
  .kind      (results.fault_kind),
  .msticky   (results.mismatch_sticky),
  .wsticky   (results.window_sticky)
);
